// ----- src/wfrf_pkg.sv -----
// wifi frame receive filter: shared types and constants
`timescale 1ns / 1ps

package wfrf_pkg;

    localparam int ADDR_W = 48;
    localparam int LEN_W = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_BROADCAST = '1;
    localparam int GROUP_BIT = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NETWORK_BSSID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE = 2'd2;

    typedef enum logic [2:0]
    {
        MODE_STRICT = 3'd0,
        MODE_STRICT_INIT = 3'd1,
        MODE_NO_ADHOC = 3'd2,
        MODE_NO_BSSID = 3'd3,
        MODE_PROMISC = 3'd4
    } filter_mode_t;

    typedef enum logic [2:0]
    {
        CAUSE_NONE = 3'd0,
        CAUSE_VERSION = 3'd1,
        CAUSE_CONTROL = 3'd2,
        CAUSE_SHORT = 3'd3,
        CAUSE_ZERO_BSSID = 3'd4
    } drop_cause_t;

    localparam logic [1:0] TYPE_CONTROL = 2'd1;
    localparam logic [1:0] DIR_TO_DS = 2'd1;
    localparam logic [1:0] DIR_FROM_DS = 2'd2;

    typedef struct packed
    {
        logic [7:0] frame_control_low;
        logic [7:0] frame_control_high;
        logic [ADDR_W-1:0] receiver_address;
        logic [ADDR_W-1:0] second_address;
        logic [ADDR_W-1:0] third_address;
        logic [LEN_W-1:0] frame_length;
    } frame_t;

    typedef struct packed
    {
        logic to_accepted;
        logic to_other;
        logic [2:0] drop_cause;
    } route_t;

endpackage

// ----- src/wifi_frame_rx_filter_unit.sv -----
// wifi frame receive filter: top level with input and result registers
// an accepted item waits in the input register, and its result is then registered in the result register
// throughput: one item per cycle while the output does not stall, set by the two-register pipeline
// the input stalls only when both registers hold items and the output stalls
// reset clears both valid bits and all configuration registers to zero
`timescale 1ns / 1ps

module wifi_frame_rx_filter_unit
    import wfrf_pkg::*;
#(
    parameter int MIN_HEADER_BYTES = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  frame_t                 frame,
    output logic                   route_valid,
    input  logic                   route_stall,
    output route_t                 route
);

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_HEADER_BYTES);

    logic [ADDR_W-1:0] own_address_reg;
    logic [ADDR_W-1:0] network_bssid_reg;
    logic [2:0]        filter_mode_reg;

    logic   frame_valid_reg;
    frame_t frame_reg;
    logic   route_valid_reg;
    route_t route_reg;
    route_t route_next;

    logic   route_ready;
    logic   frame_ready;
    logic [ADDR_W-1:0] bssid;
    logic   addr_match;

    assign route_ready = !route_valid_reg || !route_stall;
    assign frame_ready = !frame_valid_reg || route_ready;
    assign frame_stall = !frame_ready;
    assign route_valid = route_valid_reg;
    assign route = route_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            network_bssid_reg <= '0;
            filter_mode_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_address_reg <= cfg_data;
                CFG_NETWORK_BSSID: network_bssid_reg <= cfg_data;
                CFG_FILTER_MODE: filter_mode_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            route_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_ready)
            begin
                frame_valid_reg <= frame_valid;
            end
            if (route_ready)
            begin
                route_valid_reg <= frame_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            frame_reg <= frame;
        end
        if (route_ready && frame_valid_reg)
        begin
            route_reg <= route_next;
        end
    end

    always_comb
    begin
        case (frame_reg.frame_control_high[1:0])
            DIR_TO_DS: bssid = frame_reg.receiver_address;
            DIR_FROM_DS: bssid = frame_reg.second_address;
            default: bssid = frame_reg.third_address;
        endcase
    end

    assign addr_match = (frame_reg.receiver_address == own_address_reg)
        || frame_reg.receiver_address[GROUP_BIT];

    // route decision, checks in priority order
    always_comb
    begin
        route_next = '0;
        if (frame_reg.frame_control_low[1:0] != 2'd0)
        begin
            route_next.drop_cause = CAUSE_VERSION;
        end
        else if (frame_reg.frame_control_low[3:2] == TYPE_CONTROL)
        begin
            route_next.drop_cause = CAUSE_CONTROL;
        end
        else if (frame_reg.frame_length < MIN_LEN)
        begin
            route_next.drop_cause = CAUSE_SHORT;
        end
        else if (filter_mode_reg == MODE_PROMISC)
        begin
            route_next.to_accepted = 1'b1;
        end
        else if (!addr_match)
        begin
            route_next.to_other = 1'b1;
        end
        else if (filter_mode_reg == MODE_NO_ADHOC)
        begin
            route_next.to_accepted = 1'b1;
            route_next.to_other = (frame_reg.receiver_address == ADDR_BROADCAST);
        end
        else if (bssid == '0)
        begin
            route_next.drop_cause = CAUSE_ZERO_BSSID;
        end
        else if (bssid == network_bssid_reg)
        begin
            route_next.to_accepted = 1'b1;
        end
        else if ((bssid == ADDR_BROADCAST)
            || ((network_bssid_reg == '0) && (filter_mode_reg == MODE_STRICT_INIT)))
        begin
            route_next.to_accepted = 1'b1;
            route_next.to_other = 1'b1;
        end
        else if (filter_mode_reg == MODE_NO_BSSID)
        begin
            route_next.to_accepted = 1'b1;
        end
        else
        begin
            route_next.to_other = 1'b1;
        end
    end

endmodule

// ----- src/wfrf_checker.sv -----
// wifi frame receive filter: port checker and its binding
`timescale 1ns / 1ps

module wfrf_checker
    import wfrf_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   route_valid,
    input logic   route_stall,
    input route_t route
);

    // reset empties the result register
    reset_empty: assert property (@(posedge clk) !rst_n |=> !route_valid)
        else $error("result item shown during reset");

    // a dropped item goes to no port
    drop_no_port: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && route.drop_cause != CAUSE_NONE)
        |-> (!route.to_accepted && !route.to_other))
        else $error("dropped item routed to a port");

    // a routed item goes to at least one port
    routed_has_port: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && route.drop_cause == CAUSE_NONE)
        |-> (route.to_accepted || route.to_other))
        else $error("routed item has no port");

    // a stalled result holds
    stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (route_valid && route_stall) |=> (route_valid && $stable(route)))
        else $error("stalled result item changed");

endmodule

bind wifi_frame_rx_filter_unit wfrf_checker u_wfrf_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .route_valid(route_valid),
    .route_stall(route_stall),
    .route(route)
);
